// ----- rtl/four_channel_sensor_averager_assert.svh -----
// assertion macros for the sensor averager checker
`ifndef FOUR_CHANNEL_SENSOR_AVERAGER_ASSERT_SVH
`define FOUR_CHANNEL_SENSOR_AVERAGER_ASSERT_SVH
// implication checked on every edge outside reset
`define FCSA_ASSERT_IMP(label, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("fcsa check failed");
// next-cycle implication
`define FCSA_ASSERT_NXT(label, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("fcsa check failed");
`endif

// ----- rtl/fcsa_pkg.sv -----
// ----------------------------------------------------------------------------
// fcsa_pkg
// constants, tables and shared types of the sensor averager
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package fcsa_pkg;
	localparam int SEGMENTS_DEF = 31;
	localparam int RANGE_TABLES_DEF = 6;
	localparam int TBL_COLS = 64;
	localparam int TBL_ROWS = 8;

	typedef enum logic [2:0] {
		REG_CUR1_SCALE = 3'd0,
		REG_CUR2_SCALE = 3'd1,
		REG_COND1_GAIN = 3'd2,
		REG_COND2_GAIN = 3'd3,
		REG_COND1_OFS  = 3'd4,
		REG_COND2_OFS  = 3'd5,
		REG_RANGE      = 3'd6,
		REG_AVG_LEN    = 3'd7
	} reg_idx_t;

	// divider request / result between sequencer and divider
	typedef struct packed {
		logic        start;
		logic [29:0] dividend;
		logic [15:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [29:0] quot;
	} div_rsp_t;

	function automatic logic [9:0] breakpoint(input logic [5:0] i);
		logic [9:0] r;
		case (i)
			6'd0: r = 10'd997;  6'd1: r = 10'd991;  6'd2: r = 10'd961;
			6'd3: r = 10'd945;  6'd4: r = 10'd935;  6'd5: r = 10'd903;
			6'd6: r = 10'd902;  6'd7: r = 10'd846;  6'd8: r = 10'd821;
			6'd9: r = 10'd559;  6'd10: r = 10'd548; 6'd11: r = 10'd325;
			6'd12: r = 10'd214; 6'd13: r = 10'd157; 6'd14: r = 10'd121;
			6'd15: r = 10'd112; 6'd16: r = 10'd77;  6'd17: r = 10'd75;
			6'd18: r = 10'd64;  6'd19: r = 10'd50;  6'd20: r = 10'd47;
			6'd21: r = 10'd29;  6'd22: r = 10'd25;  6'd23: r = 10'd23;
			6'd24: r = 10'd20;  6'd25: r = 10'd19;  6'd26: r = 10'd18;
			6'd27: r = 10'd12;  6'd28: r = 10'd8;   6'd29: r = 10'd5;
			default: r = 10'd0;
		endcase
		return r;
	endfunction

	function automatic logic [10:0] factor(input logic [2:0] code, input logic [5:0] s);
		logic [10:0] r;
		r = 11'd0;
		case (code)
			3'd0: begin
				if (s < 6'd3) r = 11'd1176;
				else if (s < 6'd9) r = 11'd1082;
				else if (s < 6'd14) r = 11'd1024;
				else if (s < 6'd29) r = 11'd798;
				else if (s == 6'd29) r = 11'd709;
				else if (s == 6'd30) r = 11'd863;
			end
			3'd1: begin
				if (s < 6'd4) r = 11'd1185;
				else if (s < 6'd11) r = 11'd1097;
				else if (s < 6'd18) r = 11'd1024;
				else if (s < 6'd21) r = 11'd997;
				else if (s < 6'd23) r = 11'd967;
				else if (s < 6'd27) r = 11'd930;
				else if (s < 6'd31) r = 11'd904;
			end
			3'd2: begin
				if (s == 6'd0) r = 11'd1687;
				else if (s == 6'd1) r = 11'd1184;
				else if (s < 6'd6) r = 11'd1145;
				else if (s < 6'd15) r = 11'd1024;
				else if (s < 6'd20) r = 11'd972;
				else if (s < 6'd31) r = 11'd849;
			end
			3'd3: begin
				if (s < 6'd5) r = 11'd1046;
				else if (s < 6'd17) r = 11'd926;
				else if (s < 6'd22) r = 11'd1024;
				else if (s < 6'd26) r = 11'd1144;
				else if (s < 6'd31) r = 11'd1025;
			end
			3'd4: begin
				if (s < 6'd7) r = 11'd1137;
				else if (s < 6'd10) r = 11'd1033;
				else if (s < 6'd12) r = 11'd1004;
				else if (s < 6'd16) r = 11'd1024;
				else if (s < 6'd25) r = 11'd1071;
				else if (s < 6'd29) r = 11'd1004;
				else if (s < 6'd31) r = 11'd837;
			end
			3'd5: begin
				if (s < 6'd19) r = 11'd1000;
				else if (s < 6'd27) r = 11'd1024;
				else if (s < 6'd29) r = 11'd1100;
				else if (s < 6'd31) r = 11'd1203;
			end
			default: r = 11'd0;
		endcase
		return r;
	endfunction
endpackage

// ----- rtl/fcsa_divider.sv -----
// ----------------------------------------------------------------------------
// fcsa_divider
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module fcsa_divider (
	input  logic               clk,
	input  logic               arst_n,
	input  fcsa_pkg::div_req_t req,
	output fcsa_pkg::div_rsp_t rsp
);
	logic [29:0] quot_q;
	logic [16:0] rem_q;
	logic [15:0] dvs_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [16:0] trial;
	logic        fits;

	assign trial = {rem_q[15:0], quot_q[29]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd29;
			end else if (busy_q) begin
				if (cnt_q == 5'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q - 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quot_q <= req.dividend;
			rem_q  <= '0;
			dvs_q  <= req.divisor;
		end else if (busy_q) begin
			rem_q  <= fits ? trial - {1'b0, dvs_q} : trial;
			quot_q <= {quot_q[28:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;
endmodule

// ----- rtl/four_channel_sensor_averager.sv -----
// ----------------------------------------------------------------------------
// four_channel_sensor_averager
// round-robin four-slot running average with piecewise gain correction
// ----------------------------------------------------------------------------
// channel  | valid / ready          | payload
// sample   | sample_valid / _ready  | sample
// result   | result_valid / _ready  | slot, value, segment, next_mux, next_reference
// config   | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// a current sample runs two serial divides of 30 quotient bits each (scale,
// then divide by N) on the one shared divider between its transfer and
// result valid. a conductivity sample skips the scale divide, then tests
// one breakpoint a cycle and ends with a two-step multiply. the sample side
// reopens once the result is registered; a result still waiting holds only
// the next result. averages clear on reset; config is always accepted.
`timescale 1ns / 1ps
module four_channel_sensor_averager #(
	parameter int SEGMENTS     = fcsa_pkg::SEGMENTS_DEF,
	parameter int RANGE_TABLES = fcsa_pkg::RANGE_TABLES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        sample_valid,
	output logic        sample_ready,
	input  logic [9:0]  sample,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [1:0]  slot,
	output logic signed [31:0] value,
	output logic [4:0]  segment,
	output logic [2:0]  next_mux,
	output logic        next_reference,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	localparam int SW = $clog2(SEGMENTS);

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_DIV1 = 8'b0000_0010,
		ST_DIV2 = 8'b0000_0100,
		ST_UPD  = 8'b0000_1000,
		ST_SEG  = 8'b0001_0000,
		ST_MUL1 = 8'b0010_0000,
		ST_MUL2 = 8'b0100_0000,
		ST_OUT  = 8'b1000_0000
	} state_t;

	state_t state_q;

	// configuration registers
	logic [15:0] cur1_scale_q, cur2_scale_q;
	logic [23:0] c1_gain_q, c2_gain_q;
	logic [11:0] c1_ofs_q, c2_ofs_q;
	logic [5:0]  range_q;
	logic [31:0] len_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur1_scale_q <= 16'd256;
			cur2_scale_q <= 16'd256;
			c1_gain_q    <= 24'd65536;
			c2_gain_q    <= 24'd65536;
			c1_ofs_q     <= '0;
			c2_ofs_q     <= '0;
			range_q      <= '0;
			len_q        <= 32'h0101_0101;
		end else if (cfg_valid) begin
			case (fcsa_pkg::reg_idx_t'(cfg_index))
				fcsa_pkg::REG_CUR1_SCALE: cur1_scale_q <= cfg_data[15:0];
				fcsa_pkg::REG_CUR2_SCALE: cur2_scale_q <= cfg_data[15:0];
				fcsa_pkg::REG_COND1_GAIN: c1_gain_q    <= cfg_data[23:0];
				fcsa_pkg::REG_COND2_GAIN: c2_gain_q    <= cfg_data[23:0];
				fcsa_pkg::REG_COND1_OFS:  c1_ofs_q     <= cfg_data[11:0];
				fcsa_pkg::REG_COND2_OFS:  c2_ofs_q     <= cfg_data[11:0];
				fcsa_pkg::REG_RANGE:      range_q      <= cfg_data[5:0];
				fcsa_pkg::REG_AVG_LEN:    len_q        <= cfg_data;
				default: ;
			endcase
		end
	end

	// per-slot state
	logic [1:0]  ptr_q;
	logic [23:0] avg_q [4];
	logic [23:0] tgt_q;      // target, then new average
	logic        neg_q;      // sign of the average step
	logic [23:0] mag_q;      // magnitude of step
	logic [SW-1:0] seg_q;
	logic        seg_found_q;
	logic [24:0] dmag_q;     // |avg - offset|
	logic        dneg_q;
	logic [47:0] prod_q;     // |diff| * gain, fits 25+24 bits minus one
	logic [63:0] acc_q;

	fcsa_pkg::div_req_t dreq;
	fcsa_pkg::div_rsp_t drsp;

	fcsa_divider u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	logic [7:0]  n_raw;
	logic [7:0]  n_eff;
	logic [15:0] scale_raw;
	logic        is_cur;
	logic [23:0] cur_avg;
	logic [2:0]  code;
	logic [23:0] gain_sel;
	logic [11:0] ofs_sel;
	logic [10:0] fac;
	logic [24:0] new_avg;
	logic [9:0]  bp;
	logic [29:0] sat_tgt;

	assign is_cur    = ~ptr_q[1];
	assign n_raw     = len_q[8*ptr_q +: 8];
	assign n_eff     = (n_raw == 8'd0) ? 8'd1 : n_raw;
	assign scale_raw = (ptr_q == 2'd0) ? cur2_scale_q : cur1_scale_q;
	assign cur_avg   = avg_q[ptr_q];
	assign code      = ptr_q[0] ? range_q[2:0] : range_q[5:3];
	assign gain_sel  = ptr_q[0] ? c1_gain_q : c2_gain_q;
	assign ofs_sel   = ptr_q[0] ? c1_ofs_q : c2_ofs_q;
	assign fac       = ({29'd0, code} < RANGE_TABLES)
		? fcsa_pkg::factor(code, 6'(seg_q)) : 11'd0;
	assign bp        = fcsa_pkg::breakpoint(6'(seg_q));
	assign sat_tgt   = drsp.quot;
	assign new_avg   = neg_q ? {1'b0, cur_avg} - {1'b0, drsp.quot[23:0]}
		: {1'b0, cur_avg} + {1'b0, drsp.quot[23:0]};

	always_comb begin
		dreq = '0;
		if (state_q == ST_IDLE && sample_valid && ptr_q[1] == 1'b0) begin
			dreq.start    = 1'b1;
			dreq.dividend = {sample, 20'd0};
			dreq.divisor  = (scale_raw == 16'd0) ? 16'd1 : scale_raw;
		end else if (state_q == ST_UPD) begin
			dreq.start    = 1'b1;
			dreq.dividend = {6'd0, mag_q};
			dreq.divisor  = {8'd0, n_eff};
		end
	end

	assign sample_ready = (state_q == ST_IDLE);

	logic [24:0] dsum;
	assign dsum = {1'b0, tgt_q} - {1'b0, cur_avg};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			ptr_q        <= '0;
			result_valid <= 1'b0;
			for (int i = 0; i < 4; i++) avg_q[i] <= '0;
		end else begin
			case (state_q)
				ST_IDLE: if (sample_valid) begin
					if (is_cur) state_q <= ST_DIV1;
					else begin
						tgt_q   <= {2'd0, sample, 12'd0};
						state_q <= ST_DIV2;
					end
				end
				ST_DIV1: if (drsp.done) begin
					tgt_q   <= (sat_tgt > 30'hFF_FFFF) ? 24'hFF_FFFF : sat_tgt[23:0];
					state_q <= ST_DIV2;
				end
				ST_DIV2: begin
					// form sign and magnitude of target - average
					neg_q   <= dsum[24];
					mag_q   <= dsum[24] ? 24'(-dsum) : dsum[23:0];
					state_q <= ST_UPD;
				end
				ST_UPD: state_q <= ST_SEG;
				ST_SEG: if (drsp.done && !seg_found_q) begin
					avg_q[ptr_q] <= new_avg[23:0];
					tgt_q        <= new_avg[23:0];
					seg_q        <= '0;
					seg_found_q  <= 1'b1;
					if (is_cur) state_q <= ST_OUT;
				end else if (seg_found_q) begin
					// one breakpoint compare a cycle
					if (tgt_q >= {2'd0, bp, 12'd0} || seg_q == SW'(SEGMENTS - 1)) begin
						dneg_q  <= ({1'b0, tgt_q} < {1'b0, ofs_sel, 10'd0} + 25'd0);
						dmag_q  <= ({1'b0, tgt_q} < {3'd0, ofs_sel, 10'd0})
							? {3'd0, ofs_sel, 10'd0} - {1'b0, tgt_q}
							: {1'b0, tgt_q} - {3'd0, ofs_sel, 10'd0};
						state_q <= ST_MUL1;
					end else seg_q <= seg_q + SW'(1);
				end
				ST_MUL1: begin
					prod_q  <= {23'd0, dmag_q} * {24'd0, gain_sel};
					state_q <= ST_MUL2;
				end
				ST_MUL2: begin
					acc_q   <= {16'd0, prod_q} * {53'd0, fac};
					state_q <= ST_OUT;
				end
				ST_OUT: if (!result_valid) begin
					result_valid   <= 1'b1;
					slot           <= ptr_q;
					segment        <= is_cur ? 5'd0 : 5'(seg_q);
					next_mux       <= (ptr_q == 2'd0) ? 3'd2 : (ptr_q == 2'd1) ? 3'd6
						: (ptr_q == 2'd2) ? 3'd7 : 3'd0;
					next_reference <= ptr_q[0] ^ ptr_q[1];
					if (is_cur) value <= {12'd0, tgt_q[23:4]};
					else if (acc_q[63:30] > 34'h7FFF_FFFF)
						value <= dneg_q ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
					else value <= dneg_q ? -$signed(acc_q[61:30]) : $signed(acc_q[61:30]);
					ptr_q   <= ptr_q + 2'd1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			if (state_q == ST_UPD) seg_found_q <= 1'b0;
			if (result_valid && result_ready) result_valid <= 1'b0;
		end
	end
endmodule

// ----- rtl/fcsa_checker.sv -----
// ----------------------------------------------------------------------------
// fcsa_checker
// port-level checks of the sensor averager
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "four_channel_sensor_averager_assert.svh"
module fcsa_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       sample_valid,
	input logic       sample_ready,
	input logic       result_valid,
	input logic       result_ready,
	input logic [1:0] slot,
	input logic [4:0] segment
);
	`FCSA_ASSERT_NXT(a_busy_after_take, arst_n, sample_valid && sample_ready, !sample_ready)
	`FCSA_ASSERT_IMP(a_cur_seg_zero, arst_n, result_valid && !slot[1], segment == 5'd0)
	`FCSA_ASSERT_NXT(a_hold, arst_n, result_valid && !result_ready, result_valid && $stable(slot))
endmodule

bind four_channel_sensor_averager fcsa_checker u_chk (
	.clk(clk), .arst_n(arst_n), .sample_valid(sample_valid),
	.sample_ready(sample_ready), .result_valid(result_valid),
	.result_ready(result_ready), .slot(slot), .segment(segment)
);
